// ----- src/cyclic_window_double_mod_hash_core_macros.svh -----
// assertion macros for the cyclic window double-modulus hash core
`ifndef CYCLIC_WINDOW_DOUBLE_MOD_HASH_CORE_MACROS_SVH
`define CYCLIC_WINDOW_DOUBLE_MOD_HASH_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CWDMH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define CWDMH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/cwdmh_pkg.sv -----
// shared types, constants and modular arithmetic for the window hash core
package cwdmh_pkg;

    localparam int DEF_WINDOW     = 16;
    localparam int DEF_INDEX_BITS = 16;

    localparam int SYM_W   = 8;
    localparam int HASH_W  = 30;
    localparam int START_W = 16;
    localparam int WIDE_W  = 35;

    localparam longint unsigned HASH_BASE = 64'd27;
    localparam longint unsigned PRIME_A   = 64'd998244353;
    localparam longint unsigned PRIME_B   = 64'd1000000007;

    localparam logic SEL_A = 1'b0;
    localparam logic SEL_B = 1'b1;

    typedef logic [SYM_W-1:0]   sym_t;
    typedef logic [HASH_W-1:0]  hash_t;
    typedef logic [START_W-1:0] start_t;
    typedef logic [WIDE_W-1:0]  wide_t;

    typedef logic [255:0][HASH_W-1:0] drop_tbl_t;

    // symbol * 27^(window-1) mod p for every symbol value
    function automatic drop_tbl_t make_drop_tbl(int window, logic sel);
        drop_tbl_t tbl;
        longint unsigned top;
        longint unsigned v;
        top = 64'd1;
        for (int i = 1; i < window; i++)
        begin
            top = sel ? (top * HASH_BASE) % PRIME_B : (top * HASH_BASE) % PRIME_A;
        end
        for (int s = 0; s < 256; s++)
        begin
            v = 64'(s) * top;
            tbl[s] = sel ? HASH_W'(v % PRIME_B) : HASH_W'(v % PRIME_A);
        end
        return tbl;
    endfunction

    // (h - d) mod p with both operands already reduced
    function automatic hash_t mod_sub(hash_t h, hash_t d, logic sel);
        logic [HASH_W:0] p;
        logic [HASH_W:0] r;
        p = sel ? (HASH_W+1)'(PRIME_B) : (HASH_W+1)'(PRIME_A);
        if (h >= d)
        begin
            r = {1'b0, h} - {1'b0, d};
        end
        else
        begin
            r = {1'b0, h} + p - {1'b0, d};
        end
        return r[HASH_W-1:0];
    endfunction

    // x mod p for x below 32p
    function automatic hash_t mod_reduce(wide_t x, logic sel);
        wide_t p;
        wide_t r;
        p = sel ? WIDE_W'(PRIME_B) : WIDE_W'(PRIME_A);
        r = x;
        for (int i = 4; i >= 0; i--)
        begin
            if (r >= (p << i))
            begin
                r = r - (p << i);
            end
        end
        return r[HASH_W-1:0];
    endfunction

endpackage

// ----- src/cwdmh_chan_if.sv -----
// stream channel interfaces for symbols in and window hashes out
interface cwdmh_sym_if
    import cwdmh_pkg::*;
();
    logic valid;
    logic ready;
    sym_t symbol;
    logic last_symbol;

    modport source (output valid, output symbol, output last_symbol, input ready);
    modport sink (input valid, input symbol, input last_symbol, output ready);
endinterface

interface cwdmh_hash_if
    import cwdmh_pkg::*;
();
    logic   valid;
    logic   ready;
    hash_t  hash_first;
    hash_t  hash_second;
    start_t start_index;
    logic   last_result;
    logic   too_short;

    modport source (
        output valid, output hash_first, output hash_second, output start_index,
        output last_result, output too_short, input ready
    );
    modport sink (
        input valid, input hash_first, input hash_second, input start_index,
        input last_result, input too_short, output ready
    );
endinterface

// ----- src/cyclic_window_double_mod_hash_core.sv -----
// top level: rolling base-27 window hash under two primes with wrap-around windows
//
// symbols: one symbol per transaction, last_symbol marks the end of a sequence.
// hashes: one window per transaction, the hash under both primes and its start index.
// once WINDOW symbols of a sequence have arrived every symbol yields the window
// ending at it; the last symbol then yields the WINDOW-1 windows that wrap to
// the start of the sequence. a sequence shorter than WINDOW gives one result
// flagged too_short with zero hashes.
// a result is loaded into the output register from the multiply stage, which
// follows the subtract stage of its symbol. the roll datapath does the
// outgoing-symbol table lookup and subtract in the subtract stage, times 27
// plus incoming and reduction in the multiply stage, where the next symbol
// is accepted unless that stage waits. after the last symbol of a sequence the
// next one waits for idle; a full sequence first rolls its wrap windows.
// window symbols live in a circular memory and the head of the sequence in a
// second memory, both with registered reads.
// reset clears the sequence state; memory contents are not cleared.
// when the receiver stalls, the output register holds its transaction and the
// core waits in its multiply stage with symbols.ready low if it has a result.
module cyclic_window_double_mod_hash_core
    import cwdmh_pkg::*;
#(
    parameter int WINDOW     = DEF_WINDOW,
    parameter int INDEX_BITS = DEF_INDEX_BITS
)
(
    input  logic         clk,
    input  logic         rst_n,
    cwdmh_sym_if.sink    symbols,
    cwdmh_hash_if.source hashes
);

    localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W = $clog2(WINDOW + 1);

    localparam logic [PTR_W-1:0]      PTR_LAST  = PTR_W'(WINDOW - 1);
    localparam logic [FILL_W-1:0]     FILL_FULL = FILL_W'(WINDOW);
    localparam logic [FILL_W-1:0]     HEAD_LEN  = FILL_W'(WINDOW - 1);
    localparam logic [INDEX_BITS-1:0] WIN_IDX   = INDEX_BITS'(WINDOW);

    localparam drop_tbl_t DROP_A = make_drop_tbl(WINDOW, SEL_A);
    localparam drop_tbl_t DROP_B = make_drop_tbl(WINDOW, SEL_B);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SUB  = 3'b010,
        ST_MUL  = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic [PTR_W-1:0]        ptr_reg, ptr_next;
    logic [FILL_W-1:0]       fill_reg, fill_next;
    logic [INDEX_BITS-1:0]   pos_reg, pos_next;
    logic [PTR_W-1:0]        kidx_reg, kidx_next;
    logic                    wrap_reg, wrap_next;
    logic                    last_reg, last_next;
    logic                    roll_reg, roll_next;
    hash_t                   ha_reg, ha_next;
    hash_t                   hb_reg, hb_next;
    logic                    out_valid_reg, out_valid_next;

    sym_t                    rec_mem [WINDOW];
    sym_t                    head_mem [WINDOW];
    sym_t                    rec_rd_reg;
    sym_t                    head_rd_reg;
    sym_t                    in_reg;
    hash_t                   ta_reg, tb_reg;
    hash_t                   out_ha_reg, out_hb_reg;
    start_t                  out_start_reg;
    logic                    out_last_reg;
    logic                    out_short_reg;

    logic                    sym_acc;
    logic                    full;
    logic [PTR_W-1:0]        ptr_inc;
    logic                    kidx_last;
    logic                    out_free;
    logic                    emit;
    logic                    seq_done;
    logic                    go_wrap;
    logic                    mul_go;
    logic                    out_load;
    logic                    res_last;
    hash_t                   drop_a, drop_b;
    hash_t                   ha_new, hb_new;

    assign sym_acc   = symbols.valid && symbols.ready;
    assign full      = (fill_reg == FILL_FULL);
    assign ptr_inc   = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + 1'b1;
    assign kidx_last = (kidx_reg == PTR_LAST);
    assign out_free  = !out_valid_reg || hashes.ready;

    assign emit     = full || last_reg;
    assign go_wrap  = !wrap_reg && last_reg && full && (WINDOW > 1);
    assign seq_done = wrap_reg ? kidx_last
                               : (last_reg && (!full || (WINDOW == 1)));
    assign res_last = wrap_reg ? kidx_last : (last_reg && (!full || (WINDOW == 1)));
    assign mul_go   = !emit || out_free;

    assign symbols.ready = (state_reg == ST_IDLE)
                        || ((state_reg == ST_MUL) && !last_reg && !wrap_reg && mul_go);

    // outgoing symbol weighted by the top power of the base
    assign drop_a = (roll_reg || wrap_reg) ? DROP_A[rec_rd_reg] : '0;
    assign drop_b = (roll_reg || wrap_reg) ? DROP_B[rec_rd_reg] : '0;

    assign ha_new = mod_reduce(WIDE_W'(ta_reg) * WIDE_W'(HASH_BASE) + WIDE_W'(in_reg), SEL_A);
    assign hb_new = mod_reduce(WIDE_W'(tb_reg) * WIDE_W'(HASH_BASE) + WIDE_W'(in_reg), SEL_B);

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        fill_next      = fill_reg;
        pos_next       = pos_reg;
        kidx_next      = kidx_reg;
        wrap_next      = wrap_reg;
        last_next      = last_reg;
        roll_next      = roll_reg;
        ha_next        = ha_reg;
        hb_next        = hb_reg;
        out_valid_next = out_valid_reg && !hashes.ready;
        out_load       = 1'b0;

        if (sym_acc)
        begin
            ptr_next  = ptr_inc;
            fill_next = full ? fill_reg : fill_reg + 1'b1;
            pos_next  = pos_reg + 1'b1;
            last_next = symbols.last_symbol;
            roll_next = full;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (sym_acc)
                begin
                    state_next = ST_SUB;
                end
            end
            ST_SUB:
            begin
                state_next = ST_MUL;
                if (wrap_reg)
                begin
                    ptr_next  = ptr_inc;
                    kidx_next = kidx_reg + 1'b1;
                    pos_next  = pos_reg + 1'b1;
                end
            end
            ST_MUL:
            begin
                if (mul_go)
                begin
                    out_load = emit;
                    if (emit)
                    begin
                        out_valid_next = 1'b1;
                    end
                    if (seq_done)
                    begin
                        ha_next    = '0;
                        hb_next    = '0;
                        fill_next  = '0;
                        pos_next   = '0;
                        kidx_next  = '0;
                        wrap_next  = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ha_next = ha_new;
                        hb_next = hb_new;
                        if (go_wrap || wrap_reg)
                        begin
                            wrap_next  = 1'b1;
                            state_next = ST_SUB;
                        end
                        else if (sym_acc)
                        begin
                            state_next = ST_SUB;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            fill_reg      <= '0;
            pos_reg       <= '0;
            kidx_reg      <= '0;
            wrap_reg      <= 1'b0;
            last_reg      <= 1'b0;
            roll_reg      <= 1'b0;
            ha_reg        <= '0;
            hb_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            fill_reg      <= fill_next;
            pos_reg       <= pos_next;
            kidx_reg      <= kidx_next;
            wrap_reg      <= wrap_next;
            last_reg      <= last_next;
            roll_reg      <= roll_next;
            ha_reg        <= ha_next;
            hb_reg        <= hb_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // window symbols, read before write at the same address
    always_ff @(posedge clk)
    begin
        if (sym_acc)
        begin
            rec_mem[ptr_reg] <= symbols.symbol;
        end
        rec_rd_reg <= rec_mem[ptr_reg];
    end

    // first WINDOW-1 symbols of the sequence
    always_ff @(posedge clk)
    begin
        if (sym_acc && (fill_reg < HEAD_LEN))
        begin
            head_mem[fill_reg[PTR_W-1:0]] <= symbols.symbol;
        end
        head_rd_reg <= head_mem[kidx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (sym_acc)
        begin
            in_reg <= symbols.symbol;
        end
        else if ((state_reg == ST_SUB) && wrap_reg)
        begin
            in_reg <= head_rd_reg;
        end
        if (state_reg == ST_SUB)
        begin
            ta_reg <= mod_sub(ha_reg, drop_a, SEL_A);
            tb_reg <= mod_sub(hb_reg, drop_b, SEL_B);
        end
        if (out_load)
        begin
            out_ha_reg    <= full ? ha_new : '0;
            out_hb_reg    <= full ? hb_new : '0;
            out_start_reg <= full ? START_W'(pos_reg - WIN_IDX) : '0;
            out_last_reg  <= res_last;
            out_short_reg <= !full;
        end
    end

    assign hashes.valid       = out_valid_reg;
    assign hashes.hash_first  = out_ha_reg;
    assign hashes.hash_second = out_hb_reg;
    assign hashes.start_index = out_start_reg;
    assign hashes.last_result = out_last_reg;
    assign hashes.too_short   = out_short_reg;

endmodule

// ----- src/cwdmh_checker.sv -----
// port-level assertions for the window hash core and their bind
`include "cyclic_window_double_mod_hash_core_macros.svh"

module cwdmh_checker
    import cwdmh_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   in_valid,
    input logic   in_ready,
    input logic   out_valid,
    input logic   out_ready,
    input hash_t  hash_first,
    input hash_t  hash_second,
    input start_t start_index,
    input logic   last_result,
    input logic   too_short
);

    `CWDMH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(hash_first) && $stable(hash_second)
        && $stable(start_index) && $stable(last_result) && $stable(too_short),
        "stalled output transaction changed")

    `CWDMH_ASSERT_NEXT(a_accept_gap, in_valid && in_ready, !in_ready,
        "symbol accepted in back-to-back cycles")

    `CWDMH_ASSERT_NOW(a_short_form, out_valid && too_short,
        last_result && hash_first == '0 && hash_second == '0 && start_index == '0,
        "short-sequence transaction malformed")

endmodule

bind cyclic_window_double_mod_hash_core cwdmh_checker u_cwdmh_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (symbols.valid),
    .in_ready    (symbols.ready),
    .out_valid   (hashes.valid),
    .out_ready   (hashes.ready),
    .hash_first  (hashes.hash_first),
    .hash_second (hashes.hash_second),
    .start_index (hashes.start_index),
    .last_result (hashes.last_result),
    .too_short   (hashes.too_short)
);

// ----- dv/cyclic_window_double_mod_hash_core_tb.sv -----
// testbench for the cyclic window double-modulus hash core: directed and random streams
`timescale 1ns / 1ps

module cyclic_window_double_mod_hash_core_tb;
    import cwdmh_pkg::*;

    localparam int WINDOW      = DEF_WINDOW;
    localparam int DIR_ROWS    = 20;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        hash_t  hash_first;
        hash_t  hash_second;
        start_t start_index;
        logic   last_result;
        logic   too_short;
    } window_hash_t;

    typedef struct packed {
        sym_t         symbol;
        logic         last_symbol;
        logic         pinned;
        window_hash_t want;
    } stim_row_t;

    localparam window_hash_t NO_PIN = '0;
    localparam window_hash_t SHORT_SEQ = '{hash_first: '0, hash_second: '0,
        start_index: '0, last_result: 1'b1, too_short: 1'b1};
    localparam window_hash_t LONE_MAX = '{hash_first: 30'd255, hash_second: 30'd255,
        start_index: '0, last_result: 1'b0, too_short: 1'b0};

    // short sequences, then fifteen zeros and a max symbol, then one rolled window and its wrap windows
    localparam stim_row_t DIRECTED [DIR_ROWS] = '{
        '{8'hFF, 1'b1, 1'b1, SHORT_SEQ},
        '{8'h00, 1'b0, 1'b0, NO_PIN},
        '{8'h80, 1'b1, 1'b1, SHORT_SEQ},
        '{8'h00, 1'b0, 1'b0, NO_PIN},
        '{8'h00, 1'b0, 1'b0, NO_PIN},
        '{8'h00, 1'b0, 1'b0, NO_PIN},
        '{8'h00, 1'b0, 1'b0, NO_PIN},
        '{8'h00, 1'b0, 1'b0, NO_PIN},
        '{8'h00, 1'b0, 1'b0, NO_PIN},
        '{8'h00, 1'b0, 1'b0, NO_PIN},
        '{8'h00, 1'b0, 1'b0, NO_PIN},
        '{8'h00, 1'b0, 1'b0, NO_PIN},
        '{8'h00, 1'b0, 1'b0, NO_PIN},
        '{8'h00, 1'b0, 1'b0, NO_PIN},
        '{8'h00, 1'b0, 1'b0, NO_PIN},
        '{8'h00, 1'b0, 1'b0, NO_PIN},
        '{8'h00, 1'b0, 1'b0, NO_PIN},
        '{8'h00, 1'b0, 1'b0, NO_PIN},
        '{8'hFF, 1'b0, 1'b1, LONE_MAX},
        '{8'hFF, 1'b1, 1'b0, NO_PIN}
    };

    logic clk;
    logic rst_n;

    cwdmh_sym_if  sym_if ();
    cwdmh_hash_if hash_if ();

    cyclic_window_double_mod_hash_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .symbols (sym_if.sink),
        .hashes  (hash_if.source)
    );

    // predictor state
    sym_t             win_syms [WINDOW];
    sym_t             lead_syms [WINDOW];
    longint unsigned  acc_first;
    longint unsigned  acc_second;
    start_t           seq_pos;
    int               fill;
    longint unsigned  top_first;
    longint unsigned  top_second;

    window_hash_t     step_windows [$];
    window_hash_t     pending_windows [$];
    window_hash_t     want_win;
    window_hash_t     got_win;

    int src_idle_pct;
    int snk_stall_pct;
    int hold_request;
    int hold_left;

    int fail_count;
    int windows_checked;
    int short_seen;
    int wrap_seen;
    int symbols_sent;
    int sequences_sent;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic longint unsigned top_power(longint unsigned p);
        longint unsigned r;
        r = 1;
        for (int i = 1; i < WINDOW; i++)
        begin
            r = (r * HASH_BASE) % p;
        end
        return r;
    endfunction

    function automatic longint unsigned roll_hash(longint unsigned h, sym_t leaving,
                                                  sym_t entering, longint unsigned p,
                                                  longint unsigned top);
        longint unsigned drop;
        longint unsigned t;
        drop = (longint'(leaving) * top) % p;
        t = (h + p - drop) % p;
        return (t * HASH_BASE + longint'(entering)) % p;
    endfunction

    function automatic sym_t rand_symbol();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
        begin
            return 8'h00;
        end
        else if (pick == 1)
        begin
            return 8'hFF;
        end
        return sym_t'($urandom_range(255));
    endfunction

    task automatic clear_sequence();
        acc_first = 0;
        acc_second = 0;
        seq_pos = '0;
        fill = 0;
    endtask

    // windows caused by one symbol, left in step_windows
    task automatic predict_windows(input sym_t s, input logic last);
        start_t          idx;
        start_t          first;
        longint unsigned ha;
        longint unsigned hb;
        step_windows.delete();
        idx = seq_pos;
        if (fill < WINDOW)
        begin
            acc_first = (acc_first * HASH_BASE + longint'(s)) % PRIME_A;
            acc_second = (acc_second * HASH_BASE + longint'(s)) % PRIME_B;
            win_syms[fill] = s;
            if (fill < WINDOW - 1)
            begin
                lead_syms[fill] = s;
            end
            fill++;
        end
        else
        begin
            acc_first = roll_hash(acc_first, win_syms[0], s, PRIME_A, top_first);
            acc_second = roll_hash(acc_second, win_syms[0], s, PRIME_B, top_second);
            for (int k = 0; k < WINDOW - 1; k++)
            begin
                win_syms[k] = win_syms[k + 1];
            end
            win_syms[WINDOW - 1] = s;
        end
        seq_pos = seq_pos + 1'b1;
        if (fill < WINDOW)
        begin
            if (last)
            begin
                step_windows.push_back(SHORT_SEQ);
                clear_sequence();
            end
        end
        else
        begin
            first = idx - start_t'(WINDOW - 1);
            step_windows.push_back('{hash_first: hash_t'(acc_first),
                hash_second: hash_t'(acc_second), start_index: first,
                last_result: last && (WINDOW == 1), too_short: 1'b0});
            if (last)
            begin
                ha = acc_first;
                hb = acc_second;
                for (int k = 1; k < WINDOW; k++)
                begin
                    ha = roll_hash(ha, win_syms[k - 1], lead_syms[k - 1], PRIME_A, top_first);
                    hb = roll_hash(hb, win_syms[k - 1], lead_syms[k - 1], PRIME_B, top_second);
                    step_windows.push_back('{hash_first: hash_t'(ha), hash_second: hash_t'(hb),
                        start_index: first + start_t'(k), last_result: (k == WINDOW - 1),
                        too_short: 1'b0});
                end
                clear_sequence();
            end
        end
    endtask

    task automatic send_symbol(input sym_t s, input logic last, input logic pinned,
                               input window_hash_t want);
        while ($urandom_range(99) < src_idle_pct)
        begin
            sym_if.valid <= 1'b0;
            @(posedge clk);
        end
        sym_if.valid <= 1'b1;
        sym_if.symbol <= s;
        sym_if.last_symbol <= last;
        @(posedge clk);
        while (!(sym_if.valid && sym_if.ready))
        begin
            @(posedge clk);
        end
        predict_windows(s, last);
        if (pinned)
        begin
            pending_windows.push_back(want);
        end
        else
        begin
            foreach (step_windows[i])
            begin
                pending_windows.push_back(step_windows[i]);
            end
        end
        if (step_windows.size() > 1)
        begin
            wrap_seen++;
        end
        symbols_sent++;
        if (last)
        begin
            sequences_sent++;
        end
    endtask

    task automatic send_sequence(input int len);
        for (int i = 0; i < len; i++)
        begin
            send_symbol(rand_symbol(), i == len - 1, 1'b0, NO_PIN);
        end
    endtask

    task automatic random_sequences(input int n_items);
        int sent;
        int pick;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 20)
            begin
                len = $urandom_range(WINDOW - 1, 1);
            end
            else if (pick < 30)
            begin
                len = WINDOW;
            end
            else
            begin
                len = $urandom_range(3 * WINDOW, WINDOW + 1);
            end
            if (len > n_items - sent)
            begin
                len = n_items - sent;
            end
            send_sequence(len);
            sent += len;
        end
    endtask

    task automatic wait_drained();
        sym_if.valid <= 1'b0;
        while (pending_windows.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    // receiver: random stalls, with a long hold-off on request
    initial
    begin
        hash_if.ready <= 1'b0;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hash_if.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                hash_if.ready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && hash_if.valid && hash_if.ready)
        begin
            got_win = '{hash_first: hash_if.hash_first, hash_second: hash_if.hash_second,
                start_index: hash_if.start_index, last_result: hash_if.last_result,
                too_short: hash_if.too_short};
            if (pending_windows.size() == 0)
            begin
                fail_count++;
                $display("%0t unexpected transaction: expected none, got %0d %0d %0d",
                    $time, got_win.hash_first, got_win.hash_second, got_win.start_index);
            end
            else
            begin
                want_win = pending_windows.pop_front();
                windows_checked++;
                if (want_win.too_short)
                begin
                    short_seen++;
                end
                if (got_win !== want_win)
                begin
                    fail_count++;
                    $display("%0t mismatch: expected %0d %0d %0d %0b %0b, got %0d %0d %0d %0b %0b",
                        $time, want_win.hash_first, want_win.hash_second,
                        want_win.start_index, want_win.last_result, want_win.too_short,
                        got_win.hash_first, got_win.hash_second, got_win.start_index,
                        got_win.last_result, got_win.too_short);
                end
            end
        end
    end

    initial
    begin
        sym_if.valid <= 1'b0;
        sym_if.symbol <= '0;
        sym_if.last_symbol <= 1'b0;
        rst_n <= 1'b0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        hold_request = 0;
        fail_count = 0;
        windows_checked = 0;
        short_seen = 0;
        wrap_seen = 0;
        symbols_sent = 0;
        sequences_sent = 0;
        top_first = top_power(PRIME_A);
        top_second = top_power(PRIME_B);
        clear_sequence();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            send_symbol(DIRECTED[i].symbol, DIRECTED[i].last_symbol, DIRECTED[i].pinned,
                DIRECTED[i].want);
        end
        wait_drained();

        random_sequences(30);
        wait_drained();

        src_idle_pct = 73;
        random_sequences(30);
        wait_drained();

        src_idle_pct = 0;
        snk_stall_pct = 73;
        random_sequences(30);
        wait_drained();

        src_idle_pct = 9;
        snk_stall_pct = 9;
        random_sequences(30);
        wait_drained();

        // receiver holds off while the sender keeps pushing
        src_idle_pct = 0;
        snk_stall_pct = 0;
        hold_request = HOLD_CYCLES;
        send_sequence(30);
        wait_drained();

        repeat (16) @(posedge clk);
        if (pending_windows.size() != 0)
        begin
            fail_count++;
            $display("%0t %0d expected transactions never arrived", $time,
                pending_windows.size());
        end

        $display("covered %0d symbols in %0d sequences, %0d of them ending with wrap windows",
            symbols_sent, sequences_sent, wrap_seen);
        $display("checked %0d window hashes (%0d short) under idle, stall and hold-off phases",
            windows_checked, short_seen);
        if (fail_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/cwdmh_pkg.sv
src/cwdmh_chan_if.sv
src/cyclic_window_double_mod_hash_core.sv
src/cwdmh_checker.sv
dv/cyclic_window_double_mod_hash_core_tb.sv
